/* hdl/cesd_pkg.sv */
// types, character codes and helpers shared by the escape decoder modules
package cesd_pkg;

	// one raw character of the literal body
	typedef struct packed {
		logic [7:0] in_char;
		logic       end_of_string;
	} item_t;

	// one decoded result
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       last;
		logic       error;
	} result_t;

	// decode mode, one-hot
	typedef enum logic [3:0] {
		MODE_PLAIN = 4'b0001,
		MODE_ESC   = 4'b0010,
		MODE_OCT   = 4'b0100,
		MODE_HEX   = 4'b1000
	} mode_t;

	// decoder state carried between characters
	typedef struct packed {
		mode_t      mode;
		logic [1:0] digit_count;
		logic [7:0] escape_value;
		logic       hex_seen;
	} dec_state_t;

	// what one character leaves for the result queue
	typedef struct packed {
		result_t    res0;
		result_t    res1;
		logic [1:0] count;
	} dec_out_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

	localparam dec_state_t STATE_RESET = '{
		mode:         MODE_PLAIN,
		digit_count:  2'd0,
		escape_value: 8'd0,
		hex_seen:     1'b0
	};

	localparam result_t RESULT_NONE = '{
		out_byte:   8'd0,
		byte_valid: 1'b0,
		last:       1'b0,
		error:      1'b0
	};

	// character codes
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_QUESTION  = 8'h3F;
	localparam logic [7:0] CH_SQUOTE    = 8'h27;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_LOWER_N   = 8'h6E;
	localparam logic [7:0] CH_LOWER_T   = 8'h74;
	localparam logic [7:0] CH_LOWER_V   = 8'h76;
	localparam logic [7:0] CH_LOWER_B   = 8'h62;
	localparam logic [7:0] CH_LOWER_R   = 8'h72;
	localparam logic [7:0] CH_LOWER_F   = 8'h66;
	localparam logic [7:0] CH_LOWER_A   = 8'h61;
	localparam logic [7:0] CH_LOWER_X   = 8'h78;
	localparam logic [7:0] CH_DIGIT_0   = 8'h30;
	localparam logic [7:0] CH_DIGIT_7   = 8'h37;
	localparam logic [7:0] CH_DIGIT_9   = 8'h39;
	localparam logic [7:0] CH_UPPER_A   = 8'h41;
	localparam logic [7:0] CH_UPPER_F   = 8'h46;
	localparam logic [7:0] CH_LOWER_F_HEX = 8'h66;

	// control byte values
	localparam logic [7:0] BYTE_NL  = 8'd10;
	localparam logic [7:0] BYTE_TAB = 8'd9;
	localparam logic [7:0] BYTE_VT  = 8'd11;
	localparam logic [7:0] BYTE_BS  = 8'd8;
	localparam logic [7:0] BYTE_CR  = 8'd13;
	localparam logic [7:0] BYTE_FF  = 8'd12;
	localparam logic [7:0] BYTE_BEL = 8'd7;

	// octal digit test
	function automatic logic is_oct(input logic [7:0] c);
		return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_7);
	endfunction

	// hex digit test
	function automatic logic is_hex(input logic [7:0] c);
		return ((c >= CH_DIGIT_0) && (c <= CH_DIGIT_9)) ||
			((c >= CH_LOWER_A) && (c <= CH_LOWER_F_HEX)) ||
			((c >= CH_UPPER_A) && (c <= CH_UPPER_F));
	endfunction

	// hex digit value, letters add nine to their low nibble
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [3:0] v;
		if (c <= CH_DIGIT_9) begin
			v = c[3:0];
		end else begin
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

endpackage

/* hdl/cesd_decode.sv */
// next-state and result logic for one character of the literal
module cesd_decode (
	input  cesd_pkg::dec_state_t cur,
	input  cesd_pkg::item_t      item,
	output cesd_pkg::dec_state_t nxt,
	output cesd_pkg::dec_out_t   dout
);

	typedef struct packed {
		logic       hit;
		logic [7:0] value;
	} simple_t;

	// simple escape lookup
	function automatic simple_t simple_esc(input logic [7:0] c);
		simple_t s;
		s.hit = 1'b1;
		s.value = c;
		case (c)
			cesd_pkg::CH_LOWER_N:   s.value = cesd_pkg::BYTE_NL;
			cesd_pkg::CH_LOWER_T:   s.value = cesd_pkg::BYTE_TAB;
			cesd_pkg::CH_LOWER_V:   s.value = cesd_pkg::BYTE_VT;
			cesd_pkg::CH_LOWER_B:   s.value = cesd_pkg::BYTE_BS;
			cesd_pkg::CH_LOWER_R:   s.value = cesd_pkg::BYTE_CR;
			cesd_pkg::CH_LOWER_F:   s.value = cesd_pkg::BYTE_FF;
			cesd_pkg::CH_LOWER_A:   s.value = cesd_pkg::BYTE_BEL;
			cesd_pkg::CH_BACKSLASH: s.value = c;
			cesd_pkg::CH_QUESTION:  s.value = c;
			cesd_pkg::CH_SQUOTE:    s.value = c;
			cesd_pkg::CH_DQUOTE:    s.value = c;
			default:                s.hit = 1'b0;
		endcase
		return s;
	endfunction

	logic [7:0]         c;
	simple_t            simple;
	logic [1:0]         n;
	logic [1:0]         oct_cnt;
	cesd_pkg::result_t  res [2];

	assign c      = item.in_char;
	assign simple = simple_esc(c);

	// decode one character, then close the string if marked
	always_comb begin
		nxt     = cur;
		n       = 2'd0;
		res[0]  = cesd_pkg::RESULT_NONE;
		res[1]  = cesd_pkg::RESULT_NONE;
		oct_cnt = cur.digit_count + 2'd1;

		case (cur.mode)
			cesd_pkg::MODE_ESC: begin
				nxt.mode = cesd_pkg::MODE_PLAIN;
				if (simple.hit) begin
					res[n[0]] = '{out_byte: simple.value, byte_valid: 1'b1,
						last: 1'b0, error: 1'b0};
					n = n + 2'd1;
				end else if (c == cesd_pkg::CH_LOWER_X) begin
					nxt.mode         = cesd_pkg::MODE_HEX;
					nxt.escape_value = 8'd0;
					nxt.hex_seen     = 1'b0;
				end else if (cesd_pkg::is_oct(c)) begin
					nxt.mode         = cesd_pkg::MODE_OCT;
					nxt.escape_value = {5'd0, c[2:0]};
					nxt.digit_count  = 2'd1;
				end
			end
			cesd_pkg::MODE_OCT: begin
				if (cesd_pkg::is_oct(c)) begin
					nxt.escape_value = {cur.escape_value[4:0], c[2:0]};
					nxt.digit_count  = oct_cnt;
					// third digit closes the escape
					if (oct_cnt == cesd_pkg::OCT_MAX_DIGITS) begin
						res[n[0]] = '{out_byte: nxt.escape_value, byte_valid: 1'b1,
							last: 1'b0, error: 1'b0};
						n = n + 2'd1;
						nxt.mode        = cesd_pkg::MODE_PLAIN;
						nxt.digit_count = 2'd0;
					end
				end else begin
					res[n[0]] = '{out_byte: cur.escape_value, byte_valid: 1'b1,
						last: 1'b0, error: 1'b0};
					n = n + 2'd1;
					nxt.mode        = cesd_pkg::MODE_PLAIN;
					nxt.digit_count = 2'd0;
					if (c == cesd_pkg::CH_BACKSLASH) begin
						nxt.mode = cesd_pkg::MODE_ESC;
					end else begin
						res[n[0]] = '{out_byte: c, byte_valid: 1'b1,
							last: 1'b0, error: 1'b0};
						n = n + 2'd1;
					end
				end
			end
			cesd_pkg::MODE_HEX: begin
				if (cesd_pkg::is_hex(c)) begin
					nxt.escape_value = {cur.escape_value[3:0], cesd_pkg::hex_val(c)};
					nxt.hex_seen     = 1'b1;
				end else begin
					res[n[0]] = '{out_byte: cur.escape_value, byte_valid: 1'b1,
						last: 1'b0, error: 1'b0};
					n = n + 2'd1;
					nxt.mode     = cesd_pkg::MODE_PLAIN;
					nxt.hex_seen = 1'b0;
					if (c == cesd_pkg::CH_BACKSLASH) begin
						nxt.mode = cesd_pkg::MODE_ESC;
					end else begin
						res[n[0]] = '{out_byte: c, byte_valid: 1'b1,
							last: 1'b0, error: 1'b0};
						n = n + 2'd1;
					end
				end
			end
			default: begin
				if (c == cesd_pkg::CH_BACKSLASH) begin
					nxt.mode = cesd_pkg::MODE_ESC;
				end else begin
					res[n[0]] = '{out_byte: c, byte_valid: 1'b1,
						last: 1'b0, error: 1'b0};
					n = n + 2'd1;
				end
			end
		endcase

		// end of string: flush or flag a pending escape, mark the final result
		if (item.end_of_string) begin
			if ((nxt.mode == cesd_pkg::MODE_ESC) ||
				((nxt.mode == cesd_pkg::MODE_HEX) && !nxt.hex_seen)) begin
				res[n[0]] = '{out_byte: 8'd0, byte_valid: 1'b0,
					last: 1'b0, error: 1'b1};
				n = n + 2'd1;
			end else if ((nxt.mode == cesd_pkg::MODE_OCT) ||
				(nxt.mode == cesd_pkg::MODE_HEX)) begin
				res[n[0]] = '{out_byte: nxt.escape_value, byte_valid: 1'b1,
					last: 1'b0, error: 1'b0};
				n = n + 2'd1;
			end else if (n == 2'd0) begin
				res[0] = cesd_pkg::RESULT_NONE;
				n = 2'd1;
			end
			// n is one or two here, so the final result sits at n - 1
			res[~n[0]].last = 1'b1;
			nxt = cesd_pkg::STATE_RESET;
		end

		dout.res0  = res[0];
		dout.res1  = res[1];
		dout.count = n;
	end

endmodule

/* hdl/cesd_queue.sv */
// small result queue: takes up to two results a cycle, gives one
module cesd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cesd_pkg::dec_out_t  din,
	output logic                has_room,
	output logic                res_valid,
	input  logic                res_ready,
	output cesd_pkg::result_t   res
);

	cesd_pkg::result_t              entry_q [cesd_pkg::QUEUE_DEPTH];
	logic [cesd_pkg::QUEUE_AW-1:0]  wr_q;
	logic [cesd_pkg::QUEUE_AW-1:0]  rd_q;
	logic [cesd_pkg::QUEUE_CW-1:0]  cnt_q;
	logic [cesd_pkg::QUEUE_CW-1:0]  push_n;
	logic                           pop;

	// room for the two results a character may produce
	assign has_room  = cnt_q <= cesd_pkg::QUEUE_CW'(cesd_pkg::QUEUE_DEPTH - 2);
	assign res_valid = cnt_q != '0;
	assign res       = entry_q[rd_q];
	assign pop       = res_valid && res_ready;
	assign push_n    = push ? cesd_pkg::QUEUE_CW'(din.count) : '0;

	// result storage
	always_ff @(posedge clk) begin
		if (push && (din.count != 2'd0)) begin
			entry_q[wr_q] <= din.res0;
		end
		if (push && (din.count == 2'd2)) begin
			entry_q[wr_q + cesd_pkg::QUEUE_AW'(1)] <= din.res1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + push_n[cesd_pkg::QUEUE_AW-1:0];
			if (pop) begin
				rd_q <= rd_q + cesd_pkg::QUEUE_AW'(1);
			end
			cnt_q <= cnt_q + push_n - cesd_pkg::QUEUE_CW'(pop);
		end
	end

endmodule

/* hdl/c_escape_sequence_decoder.sv */
// C string literal escape decoder, top level
// Takes one character of a literal body per cycle and delivers the decoded bytes, one
// result per cycle, through a four-entry result queue. A character produces zero, one
// or two results; the input accepts whenever the queue has room for two, so a stream
// of characters runs at one per cycle as long as results are taken at one per cycle
// and the string does not average more than one result per character. The escape state
// updates in the same cycle a character is accepted, so characters may follow each
// other back to back. The final result of each string carries last; error is set
// when the string ends on a lone backslash or on a hex marker with no digits.
module c_escape_sequence_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  cesd_pkg::item_t    item,
	output logic               res_valid,
	input  logic               res_ready,
	output cesd_pkg::result_t  res
);

	cesd_pkg::dec_state_t state_q;
	cesd_pkg::dec_state_t state_nxt;
	cesd_pkg::dec_out_t   dout;
	logic                 accept;

	assign accept = item_valid && item_ready;

	// character decode
	cesd_decode u_decode (
		.cur  (state_q),
		.item (item),
		.nxt  (state_nxt),
		.dout (dout)
	);

	// escape state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cesd_pkg::STATE_RESET;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// result queue
	cesd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.din       (dout),
		.has_room  (item_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule
